>>> design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, reset by i_rst_n.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define QWO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that must never hold outside reset
`define QWO_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> design/qwo_pkg.sv
// ============================================================================
// qwo_pkg
// Widths, CORDIC constants and arctangent table for the wheel odometry block.
// ============================================================================
package qwo_pkg;

    localparam int unsigned MA_W   = 64;   // serial multiplier, multiplicand
    localparam int unsigned MB_W   = 32;   // serial multiplier, multiplier
    localparam int unsigned PROD_W = MA_W + MB_W;
    localparam int unsigned NUM_W  = 88;   // divider dividend / quotient
    localparam int unsigned DEN_W  = 20;   // divider divisor
    localparam int unsigned CRD_W  = 34;   // CORDIC datapath
    localparam int unsigned ATAN_N = 31;
    localparam int unsigned ATAN_IW = 5;

    localparam logic [CRD_W-1:0] CORDIC_GAIN = CRD_W'(652032874);

    localparam logic [31:0] ATAN_BAM [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
    };

endpackage

>>> design/qwo_mul.sv
// ============================================================================
// qwo_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ============================================================================
module qwo_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [qwo_pkg::MA_W-1:0]   i_a,
    input  logic [qwo_pkg::MB_W-1:0]   i_b,
    output logic                       o_done,
    output logic [qwo_pkg::PROD_W-1:0] o_prod
);
    import qwo_pkg::*;

    localparam int unsigned CW = $clog2(MB_W);

    logic [PROD_W-1:0] r_acc;
    logic [MA_W-1:0]   r_a;
    logic [MB_W-1:0]   r_b;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [MA_W:0]     w_sum;

    assign w_sum = {1'b0, r_acc[PROD_W-1:MB_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(MB_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(MB_W - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[MB_W-1:1]};
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> design/qwo_div.sv
// ============================================================================
// qwo_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ============================================================================
module qwo_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [qwo_pkg::NUM_W-1:0] i_num,
    input  logic [qwo_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [qwo_pkg::NUM_W-1:0] o_quot
);
    import qwo_pkg::*;

    localparam int unsigned CW = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(NUM_W - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> design/qwo_cordic.sv
// ============================================================================
// qwo_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a 2 pi binary angle.
// ============================================================================
module qwo_cordic #(
    parameter int unsigned STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import qwo_pkg::*;

    localparam logic [ATAN_IW-1:0] LAST = ATAN_IW'(STEPS - 1);
    localparam logic signed [CRD_W-1:0] ONE_P = CRD_W'(1 << 30);
    localparam logic signed [CRD_W-1:0] ONE_N = -CRD_W'(1 << 30);

    logic signed [CRD_W-1:0] r_x, r_y, r_z;
    logic [ATAN_IW-1:0]      r_cnt;
    logic                    r_flip;
    logic                    r_busy;
    logic                    r_done;
    logic signed [CRD_W-1:0] w_xs, w_ys, w_at, w_fx, w_fy;
    logic                    w_flip;
    logic [31:0]             w_ang;

    assign w_flip = i_angle[31] ^ i_angle[30];
    assign w_ang  = i_angle ^ {w_flip, 31'd0};
    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_at   = CRD_W'(ATAN_BAM[r_cnt]);
    assign w_fx   = r_flip ? -r_x : r_x;
    assign w_fy   = r_flip ? -r_y : r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {{(CRD_W-32){w_ang[31]}}, w_ang};
            r_flip <= w_flip;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (!r_z[CRD_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        priority if (w_fx > ONE_P) o_cos = 32'(ONE_P);
        else if (w_fx < ONE_N)     o_cos = 32'(ONE_N);
        else                       o_cos = 32'(w_fx);
        priority if (w_fy > ONE_P) o_sin = 32'(ONE_P);
        else if (w_fy < ONE_N)     o_sin = 32'(ONE_N);
        else                       o_sin = 32'(w_fy);
    end

    assign o_done = r_done;

endmodule

>>> design/quadrature_wheel_odometry.sv
// ============================================================================
// quadrature_wheel_odometry
// Quadrature tick counting and midpoint-heading odometry for a two-wheel base.
// ============================================================================
// Pin sample: a new transaction each cycle while idle.
// Integrating update: eight serial multiplies, two serial divides and two
//   CORDIC passes, all on one shared sequencer; one update at a time.
// Reset (i_rst_n low, synchronous): counts, pose and flags cleared, registers
//   back to their defaults, no result pending.
module quadrature_wheel_odometry #(
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic               i_left_a,
    input  logic               i_left_b,
    input  logic               i_right_a,
    input  logic               i_right_b,
    input  logic [19:0]        i_elapsed_us,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_x_pos,
    output logic signed [31:0] o_y_pos,
    output logic signed [31:0] o_orient_z,
    output logic signed [31:0] o_orient_w,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity,
    output logic signed [31:0] o_left_wheel_distance,
    output logic signed [31:0] o_right_wheel_distance,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import qwo_pkg::*;
    `include "assert_macros.svh"

    localparam logic [31:0] MPT_RST      = 32'd5237766;
    localparam logic [30:0] APT_RST      = 31'd1812209;
    localparam logic [31:0] US_PER_S     = 32'd1000000;
    localparam logic [31:0] FOUR_PI_MEGA = 32'd12566371;

    typedef enum logic {REG_MPT = 1'b0, REG_APT = 1'b1} t_reg_idx;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_MUL_P    = 14'b00000000000010,
        S_MUL_Y    = 14'b00000000000100,
        S_COR_MID  = 14'b00000000001000,
        S_MUL_X    = 14'b00000000010000,
        S_MUL_YP   = 14'b00000000100000,
        S_COR_HEAD = 14'b00000001000000,
        S_MUL_LF   = 14'b00000010000000,
        S_DIV_L    = 14'b00000100000000,
        S_MUL_AF   = 14'b00001000000000,
        S_DIV_A    = 14'b00010000000000,
        S_MUL_WL   = 14'b00100000000000,
        S_MUL_WR   = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } t_state;

    function automatic logic [31:0] f_sat(input logic [NUM_W-1:0] v, input logic neg);
        logic [31:0] res;
        if (neg) begin
            res = (v > NUM_W'(32'h80000000)) ? 32'h80000000 : 32'(-v[31:0]);
        end else begin
            res = (v > NUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : v[31:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;
    logic        r_launch, n_launch;
    logic [31:0] r_mpt, n_mpt;
    logic [30:0] r_apt, n_apt;
    logic [31:0] r_left_cnt, n_left_cnt, r_right_cnt, n_right_cnt;
    logic [31:0] r_lat_left, n_lat_left, r_lat_right, n_lat_right;
    logic        r_last_la, n_last_la, r_last_ra, n_last_ra;
    logic        r_seeded, n_seeded, r_started, n_started;
    logic [31:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y, r_heading, n_heading;
    logic [32:0] r_smag, n_smag, r_dmag, n_dmag;
    logic        r_sneg, n_sneg, r_dneg, n_dneg;
    logic [19:0] r_us, n_us;
    logic [63:0] r_p, n_p;
    logic [62:0] r_yd, n_yd;
    logic signed [31:0] r_c, n_c, r_s, n_s;
    logic [31:0] r_oz, n_oz, r_ow, n_ow, r_lin, n_lin, r_ang, n_ang;
    logic [31:0] r_wl, n_wl, r_wr, n_wr;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_ox, n_ox, r_oy, n_oy, r_ooz, n_ooz, r_oow, n_oow;
    logic [31:0] r_olin, n_olin, r_oang, n_oang, r_owl, n_owl, r_owr, n_owr;

    logic              w_acc, w_cfg_wr;
    logic [31:0]       w_dl, w_dr;
    logic [32:0]       w_sum, w_diff;
    logic [31:0]       w_ydl, w_mid;
    logic [64:0]       w_dist_sum;
    logic [47:0]       w_dist_mag;
    logic [31:0]       w_cabs, w_sabs, w_labs, w_rabs;
    logic              w_term_neg;
    logic [61:0]       w_term;
    logic [63:0]       w_wsum;
    logic [NUM_W-1:0]  w_wheel;

    logic              w_mul_start, w_mul_done;
    logic [MA_W-1:0]   w_mul_a;
    logic [MB_W-1:0]   w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic              w_div_start, w_div_done;
    logic [NUM_W-1:0]  w_quot;
    logic              w_cor_start, w_cor_done;
    logic [31:0]       w_cor_ang;
    logic signed [31:0] w_cos, w_sin;
    logic              w_in_mul;

    assign w_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_wr = psel && penable && pwrite;

    assign w_dl   = r_left_cnt - r_lat_left;
    assign w_dr   = r_right_cnt - r_lat_right;
    assign w_sum  = {w_dl[31], w_dl} + {w_dr[31], w_dr};
    assign w_diff = {w_dr[31], w_dr} - {w_dl[31], w_dl};

    assign w_ydl      = r_dneg ? -r_yd[31:0] : r_yd[31:0];
    assign w_mid      = {r_heading[30:0], 1'b0} + w_ydl;
    assign w_dist_sum = {1'b0, r_p} + 65'h10000;
    assign w_dist_mag = w_dist_sum[64:17];
    assign w_cabs     = r_c[31] ? 32'(-r_c) : 32'(r_c);
    assign w_sabs     = r_s[31] ? 32'(-r_s) : 32'(r_s);
    assign w_labs     = r_left_cnt[31] ? -r_left_cnt : r_left_cnt;
    assign w_rabs     = r_right_cnt[31] ? -r_right_cnt : r_right_cnt;

    assign w_term_neg = r_sneg ^ ((r_state == S_MUL_X) ? r_c[31] : r_s[31]);
    assign w_term     = (w_term_neg ? -w_prod[61:0] : w_prod[61:0]) + 62'(1 << 29);
    assign w_wsum     = w_prod[63:0] + 64'h8000;
    assign w_wheel    = NUM_W'(w_wsum[63:16]);

    assign w_in_mul = (r_state == S_MUL_P) || (r_state == S_MUL_Y) ||
                      (r_state == S_MUL_X) || (r_state == S_MUL_YP) ||
                      (r_state == S_MUL_LF) || (r_state == S_MUL_AF) ||
                      (r_state == S_MUL_WL) || (r_state == S_MUL_WR);

    assign w_mul_start = r_launch && w_in_mul;
    assign w_div_start = r_launch && ((r_state == S_DIV_L) || (r_state == S_DIV_A));
    assign w_cor_start = r_launch && ((r_state == S_COR_MID) || (r_state == S_COR_HEAD));
    assign w_cor_ang   = (r_state == S_COR_MID) ? w_mid : r_heading;

    always_comb begin
        unique case (r_state)
            S_MUL_P: begin
                w_mul_a = MA_W'(r_smag);
                w_mul_b = r_mpt;
            end
            S_MUL_Y: begin
                w_mul_a = MA_W'(r_dmag);
                w_mul_b = {1'b0, r_apt};
            end
            S_MUL_X: begin
                w_mul_a = MA_W'(w_dist_mag);
                w_mul_b = w_cabs;
            end
            S_MUL_YP: begin
                w_mul_a = MA_W'(w_dist_mag);
                w_mul_b = w_sabs;
            end
            S_MUL_LF: begin
                w_mul_a = r_p;
                w_mul_b = US_PER_S;
            end
            S_MUL_AF: begin
                w_mul_a = {1'b0, r_yd};
                w_mul_b = FOUR_PI_MEGA;
            end
            S_MUL_WL: begin
                w_mul_a = MA_W'(w_labs);
                w_mul_b = r_mpt;
            end
            S_MUL_WR: begin
                w_mul_a = MA_W'(w_rabs);
                w_mul_b = r_mpt;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    qwo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    qwo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[NUM_W-1:0]),
        .i_den   (r_us),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    qwo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (w_cor_ang),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_comb begin
        n_state     = r_state;
        n_launch    = 1'b0;
        n_mpt       = r_mpt;
        n_apt       = r_apt;
        n_left_cnt  = r_left_cnt;
        n_right_cnt = r_right_cnt;
        n_lat_left  = r_lat_left;
        n_lat_right = r_lat_right;
        n_last_la   = r_last_la;
        n_last_ra   = r_last_ra;
        n_seeded    = r_seeded;
        n_started   = r_started;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_heading   = r_heading;
        n_smag      = r_smag;
        n_sneg      = r_sneg;
        n_dmag      = r_dmag;
        n_dneg      = r_dneg;
        n_us        = r_us;
        n_p         = r_p;
        n_yd        = r_yd;
        n_c         = r_c;
        n_s         = r_s;
        n_oz        = r_oz;
        n_ow        = r_ow;
        n_lin       = r_lin;
        n_ang       = r_ang;
        n_wl        = r_wl;
        n_wr        = r_wr;
        n_out_valid = r_out_valid && i_out_stall;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_ooz       = r_ooz;
        n_oow       = r_oow;
        n_olin      = r_olin;
        n_oang      = r_oang;
        n_owl       = r_owl;
        n_owr       = r_owr;

        if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_MPT: n_mpt = pwdata;
                REG_APT: n_apt = pwdata[30:0];
                default: n_mpt = r_mpt;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc && !i_op) begin
                    if (r_seeded && i_left_a && !r_last_la) begin
                        n_left_cnt = i_left_b ? r_left_cnt + 1'b1 : r_left_cnt - 1'b1;
                    end
                    if (r_seeded && i_right_a && !r_last_ra) begin
                        n_right_cnt = i_right_b ? r_right_cnt + 1'b1 : r_right_cnt - 1'b1;
                    end
                    n_seeded  = 1'b1;
                    n_last_la = i_left_a;
                    n_last_ra = i_right_a;
                end else if (w_acc && !r_started) begin
                    n_started   = 1'b1;
                    n_lat_left  = r_left_cnt;
                    n_lat_right = r_right_cnt;
                end else if (w_acc && (i_elapsed_us != '0)) begin
                    n_sneg      = w_sum[32];
                    n_smag      = w_sum[32] ? -w_sum : w_sum;
                    n_dneg      = w_diff[32];
                    n_dmag      = w_diff[32] ? -w_diff : w_diff;
                    n_us        = i_elapsed_us;
                    n_lat_left  = r_left_cnt;
                    n_lat_right = r_right_cnt;
                    n_state     = S_MUL_P;
                    n_launch    = 1'b1;
                end
            end
            S_MUL_P: if (w_mul_done) begin
                n_p      = w_prod[63:0];
                n_state  = S_MUL_Y;
                n_launch = 1'b1;
            end
            S_MUL_Y: if (w_mul_done) begin
                n_yd     = w_prod[62:0];
                n_state  = S_COR_MID;
                n_launch = 1'b1;
            end
            S_COR_MID: if (w_cor_done) begin
                n_c       = w_cos;
                n_s       = w_sin;
                n_heading = r_heading + w_ydl;
                n_state   = S_MUL_X;
                n_launch  = 1'b1;
            end
            S_MUL_X: if (w_mul_done) begin
                n_pos_x  = r_pos_x + w_term[61:30];
                n_state  = S_MUL_YP;
                n_launch = 1'b1;
            end
            S_MUL_YP: if (w_mul_done) begin
                n_pos_y  = r_pos_y + w_term[61:30];
                n_state  = S_COR_HEAD;
                n_launch = 1'b1;
            end
            S_COR_HEAD: if (w_cor_done) begin
                n_oz     = w_sin;
                n_ow     = w_cos;
                n_state  = S_MUL_LF;
                n_launch = 1'b1;
            end
            S_MUL_LF: if (w_mul_done) begin
                n_state  = S_DIV_L;
                n_launch = 1'b1;
            end
            S_DIV_L: if (w_div_done) begin
                n_lin    = f_sat(w_quot >> 17, r_sneg);
                n_state  = S_MUL_AF;
                n_launch = 1'b1;
            end
            S_MUL_AF: if (w_mul_done) begin
                n_state  = S_DIV_A;
                n_launch = 1'b1;
            end
            S_DIV_A: if (w_div_done) begin
                n_ang    = f_sat(w_quot >> 16, r_dneg);
                n_state  = S_MUL_WL;
                n_launch = 1'b1;
            end
            S_MUL_WL: if (w_mul_done) begin
                n_wl     = f_sat(w_wheel, r_left_cnt[31]);
                n_state  = S_MUL_WR;
                n_launch = 1'b1;
            end
            S_MUL_WR: if (w_mul_done) begin
                n_wr    = f_sat(w_wheel, r_right_cnt[31]);
                n_state = S_DONE;
            end
            S_DONE: if (!r_out_valid || !i_out_stall) begin
                n_ox        = r_pos_x;
                n_oy        = r_pos_y;
                n_ooz       = r_oz;
                n_oow       = r_ow;
                n_olin      = r_lin;
                n_oang      = r_ang;
                n_owl       = r_wl;
                n_owr       = r_wr;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_mpt       <= MPT_RST;
            r_apt       <= APT_RST;
            r_left_cnt  <= '0;
            r_right_cnt <= '0;
            r_lat_left  <= '0;
            r_lat_right <= '0;
            r_last_la   <= 1'b0;
            r_last_ra   <= 1'b0;
            r_seeded    <= 1'b0;
            r_started   <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_mpt       <= n_mpt;
            r_apt       <= n_apt;
            r_left_cnt  <= n_left_cnt;
            r_right_cnt <= n_right_cnt;
            r_lat_left  <= n_lat_left;
            r_lat_right <= n_lat_right;
            r_last_la   <= n_last_la;
            r_last_ra   <= n_last_ra;
            r_seeded    <= n_seeded;
            r_started   <= n_started;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smag <= n_smag;
        r_sneg <= n_sneg;
        r_dmag <= n_dmag;
        r_dneg <= n_dneg;
        r_us   <= n_us;
        r_p    <= n_p;
        r_yd   <= n_yd;
        r_c    <= n_c;
        r_s    <= n_s;
        r_oz   <= n_oz;
        r_ow   <= n_ow;
        r_lin  <= n_lin;
        r_ang  <= n_ang;
        r_wl   <= n_wl;
        r_wr   <= n_wr;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_ooz  <= n_ooz;
        r_oow  <= n_oow;
        r_olin <= n_olin;
        r_oang <= n_oang;
        r_owl  <= n_owl;
        r_owr  <= n_owr;
    end

    assign o_in_stall             = (r_state != S_IDLE);
    assign o_out_valid            = r_out_valid;
    assign o_x_pos                = r_ox;
    assign o_y_pos                = r_oy;
    assign o_orient_z             = r_ooz;
    assign o_orient_w             = r_oow;
    assign o_linear_velocity      = r_olin;
    assign o_angular_velocity     = r_oang;
    assign o_left_wheel_distance  = r_owl;
    assign o_right_wheel_distance = r_owr;
    assign prdata = (t_reg_idx'(paddr[2]) == REG_APT) ? {1'b0, r_apt} : r_mpt;
    assign pready = 1'b1;

    `QWO_ASSERT(a_mul_done_in_mul, w_mul_done |-> w_in_mul, "multiplier done outside a multiply phase")
    `QWO_ASSERT(a_pin_keeps_pose, (w_acc && !i_op) |=> ($stable(r_pos_x) && $stable(r_heading)), "pin sample moved the pose")
    `QWO_ASSERT(a_result_from_done, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result raised outside the done phase")
    `QWO_NEVER(a_units_exclusive, (w_cor_done && w_div_done) || (w_mul_done && w_cor_done), "two units finished together")

endmodule
